@@ rtl/crsf_pkg.sv @@
// ----------------------------------------------------------------------------
// CRSF telemetry scheduler package
// Shared types, codes and constants for the frame scheduler core.
// ----------------------------------------------------------------------------
`default_nettype none

package crsf_pkg;

    localparam int unsigned FrameBufferBytesDef = 64;
    localparam int unsigned NumSensors = 15;
    localparam int unsigned NumKinds = 5;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_TAKEN = 2'd2;

    localparam logic [2:0] REG_DEST      = 3'd0;
    localparam logic [2:0] REG_BATT_INTV = 3'd1;
    localparam logic [2:0] REG_MODE_INTV = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  sensor_select;
        logic signed [31:0] sensor_value;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [2:0] frame_kind;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ENC,
        ST_EMIT,
        ST_CRC
    } t_state;

    // Frame type byte per kind.
    function automatic logic [7:0] kind_type(input logic [2:0] k);
        case (k)
            3'd0: kind_type = 8'h08;
            3'd1: kind_type = 8'h02;
            3'd2: kind_type = 8'h07;
            3'd3: kind_type = 8'h1E;
            default: kind_type = 8'h21;
        endcase
    endfunction

    function automatic logic [4:0] payload_len(input logic [2:0] k, input logic [2:0] m);
        case (k)
            3'd0: payload_len = 5'd8;
            3'd1: payload_len = 5'd15;
            3'd2: payload_len = 5'd2;
            3'd3: payload_len = 5'd6;
            default: begin
                case (m)
                    3'd0: payload_len = 5'd5;
                    3'd1: payload_len = 5'd6;
                    3'd2: payload_len = 5'd8;
                    3'd3: payload_len = 5'd4;
                    default: payload_len = 5'd8;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] mode_char(input logic [2:0] m, input logic [2:0] n);
        logic [63:0] s;
        case (m)
            3'd0: s = {"ACRO", 32'h0};
            3'd1: s = {"ANGLE", 24'h0};
            3'd2: s = {"HORIZON", 8'h0};
            3'd3: s = {"GPS", 40'h0};
            default: s = {"UNKNOWN", 8'h0};
        endcase
        mode_char = s[63 - 8*n -: 8];
    endfunction

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int i = 0; i < 8; i++) begin
            x = x[7] ? ((x << 1) ^ 8'hD5) : (x << 1);
        end
        crc_step = x;
    endfunction

endpackage

`default_nettype wire

@@ rtl/crsf_mul.sv @@
// ----------------------------------------------------------------------------
// CRSF shared multiplier
// Registered signed 33 x 25 multiply, used for every value scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [24:0] i_b,
    output      logic signed [57:0] o_p
);
    logic signed [57:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 58'(i_a) * 58'(i_b);
    end

    assign o_p = r_p;
endmodule

`default_nettype wire

@@ rtl/crsf_telemetry_frame_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// CRSF telemetry frame scheduler core
// Stores sensor values, schedules frame kinds by interval and emits encoded
// frames one byte per transaction with a running CRC-8.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in      | input     | t_in_item  (operation, sensor_select, value, now_ms)
// out     | output    | t_out_item (frame_byte, frame_kind, last_byte)
// cfg     | input     | index 0 address, 1..5 intervals
//
// Store and frame-taken transactions complete while idle. A tick scans the
// kinds in turn, issues each field of the due kind to the shared multiplier,
// waits while the last product lands, then emits the frame bytes.
// Reset is synchronous and restores the control, sensor, schedule and config
// registers, but not the frame buffer or output data. Input is not taken
// while a tick is in progress; output stalls hold the byte sequencer.
`default_nettype none

module crsf_telemetry_frame_scheduler_core #(
    parameter int unsigned FRAME_BUFFER_BYTES = crsf_pkg::FrameBufferBytesDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire crsf_pkg::t_in_item i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      crsf_pkg::t_out_item o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import crsf_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_sens [NumSensors];
    logic [31:0] r_last [NumKinds];
    logic [15:0] r_intv [NumKinds];
    logic [7:0]  r_dest;
    logic        r_pend;
    logic [31:0] r_now;
    logic [2:0]  r_kind;
    logic [3:0]  r_fld;
    logic [7:0]  r_buf [19];
    logic [4:0]  r_eidx;
    logic [4:0]  r_tot;
    logic [7:0]  r_crc;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;
    logic [5:0]  r_hmod;
    logic [3:0]  r_psel;
    logic        r_pv;

    logic        acc;
    logic [31:0] diff;
    logic        due;
    logic [2:0]  mcode;
    logic [4:0]  plen;
    logic signed [32:0] ma;
    logic signed [24:0] mb;
    logic signed [57:0] mp;
    logic [3:0]  sidx;
    logic        fld_done;
    logic        out_free;
    logic [13:0] hu;
    logic [27:0] hq;
    logic [13:0] hr;

    assign acc = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data = '{frame_byte: r_ob, frame_kind: r_kind, last_byte: r_ol};

    assign diff = r_now - r_last[r_kind];
    assign due = diff >= {16'd0, r_intv[r_kind]};

    // Heading in 2^19 units (8 deg) modulo 45 (360 deg = 45 * 2^19 in Q16.16), by
    // reciprocal multiplication on the offset upper bits at store time.
    assign hu = {i_in_data.sensor_value[31], i_in_data.sensor_value[31:19]} + 14'd4140;
    assign hq = hu * 14'd11651;
    assign hr = hu - ({5'd0, hq[27:19]} * 14'd45);

    always_comb begin
        logic signed [31:0] m;
        m = signed'(r_sens[14]);
        mcode = (m < 0 || m > 3) ? 3'd4 : m[2:0];
    end
    assign plen = payload_len(r_kind, mcode);

    // Field sequencing: select multiplier operands per (kind, field).
    always_comb begin
        logic signed [32:0] v;
        sidx = 4'd0;
        ma = '0;
        mb = 25'sd1;
        fld_done = 1'b0;
        case (r_kind)
            3'd0: begin sidx = r_fld; fld_done = (r_fld == 4'd3); end
            3'd1: begin sidx = 4'd4 + r_fld; fld_done = (r_fld == 4'd5); end
            3'd2: begin sidx = 4'd10; fld_done = 1'b1; end
            3'd3: begin sidx = 4'd11 + r_fld; fld_done = (r_fld == 4'd2); end
            default: begin sidx = 4'd14; fld_done = 1'b1; end
        endcase
        v = 33'(signed'(r_sens[sidx]));
        case (sidx)
            4'd0, 4'd1: begin ma = (v < 0) ? '0 : v; mb = 25'sd10; end
            4'd4, 4'd5: begin
                ma = (v < -33'sd11796480) ? -33'sd11796480 :
                     (v > 33'sd11796480) ? 33'sd11796480 : v;
                mb = 25'sd10000000;
            end
            4'd6: begin ma = (v < 0) ? '0 : v; mb = 25'sd36; end
            4'd7: begin ma = signed'({8'd0, r_hmod, r_sens[7][18:0]}); mb = 25'sd100; end
            4'd10: begin ma = v; mb = 25'sd100; end
            4'd11, 4'd12, 4'd13: begin ma = v; mb = 25'sd11438190; end
            default: begin ma = v; mb = 25'sd1; end
        endcase
    end

    crsf_mul u_mul (.i_clk(i_clk), .i_a(ma), .i_b(mb), .o_p(mp));

    function automatic logic signed [57:0] tdiv(input logic signed [57:0] p, input int sh);
        logic signed [57:0] q;
        q = p >>> sh;
        if (p < 0 && (p & ((58'sd1 <<< sh) - 1)) != 0) q = q + 1;
        return q;
    endfunction

    function automatic logic signed [57:0] clampv(input logic signed [57:0] x,
                                                   input logic signed [57:0] lo,
                                                   input logic signed [57:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc && i_in_data.operation == OP_TICK && !r_pend) n_state = ST_SCAN;
            ST_SCAN: begin
                if (due && (32'(plen) + 32'd4 <= 32'(FRAME_BUFFER_BYTES))) n_state = ST_ENC;
                else if (r_kind == 3'd4) n_state = ST_IDLE;
            end
            ST_ENC: if (fld_done) n_state = ST_CRC;
            ST_CRC: if (!r_pv) n_state = ST_EMIT;
            ST_EMIT: if (out_free && r_eidx == r_tot) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [57:0] q;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < NumSensors; i++) r_sens[i] <= '0;
            for (int i = 0; i < NumKinds; i++) r_last[i] <= '0;
            r_intv[0] <= 16'd1000; r_intv[1] <= 16'd1000; r_intv[2] <= 16'd200;
            r_intv[3] <= 16'd100;  r_intv[4] <= 16'd1000;
            r_dest <= 8'd200;
            r_pend <= 1'b0;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_crc <= '0;
            r_kind <= '0;
            r_hmod <= '0;
            r_eidx <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DEST) r_dest <= i_cfg_data[7:0];
                else if (i_cfg_index <= REG_MODE_INTV)
                    r_intv[i_cfg_index - REG_BATT_INTV] <= i_cfg_data;
            end
            r_pv <= (r_state == ST_ENC);
            case (r_state)
                ST_IDLE: if (acc) begin
                    if (i_in_data.operation == OP_STORE && i_in_data.sensor_select != 4'd15) begin
                        r_sens[i_in_data.sensor_select] <= i_in_data.sensor_value;
                        if (i_in_data.sensor_select == 4'd7) r_hmod <= hr[5:0];
                    end
                    if (i_in_data.operation == OP_TAKEN) r_pend <= 1'b0;
                    r_now <= i_in_data.now_ms;
                    r_kind <= '0;
                    r_fld <= '0;
                end
                ST_SCAN: begin
                    r_fld <= '0;
                    if (due && (32'(plen) + 32'd4 <= 32'(FRAME_BUFFER_BYTES))) begin
                        r_buf[0] <= {3'd0, plen} + 8'd2;
                        r_buf[1] <= kind_type(r_kind);
                        r_tot <= plen + 5'd4;
                        r_last[r_kind] <= r_now;
                        r_pend <= 1'b1;
                        r_crc <= crc_step(8'd0, kind_type(r_kind));
                        if (r_kind == 3'd4)
                            for (int n = 0; n < 8; n++)
                                r_buf[2 + n] <= mode_char(mcode, 3'(n));
                    end else if (r_kind != 3'd4) begin
                        r_kind <= r_kind + 3'd1;
                    end
                end
                ST_ENC: begin
                    r_psel <= sidx;
                    r_fld <= r_fld + 4'd1;
                end
                ST_CRC: r_eidx <= '0;
                ST_EMIT: if (out_free && r_eidx != r_tot) begin
                    r_ob <= (r_eidx == 5'd0) ? r_dest :
                            (r_eidx == r_tot - 5'd1) ? r_crc : r_buf[r_eidx - 5'd1];
                    r_ol <= (r_eidx == r_tot - 5'd1);
                    if (r_eidx >= 5'd2 && r_eidx < r_tot - 5'd2)
                        r_crc <= crc_step(r_crc, r_buf[r_eidx]);
                    r_eidx <= r_eidx + 5'd1;
                end
                default: ;
            endcase
            if (r_state == ST_EMIT && out_free && r_eidx != r_tot) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (r_pv) begin
                case (r_psel)
                    4'd0, 4'd1: begin
                        q = clampv(tdiv(mp, 16), 0, 65535);
                        r_buf[2 + 2*r_psel] <= q[15:8]; r_buf[3 + 2*r_psel] <= q[7:0];
                    end
                    4'd2: begin
                        q = clampv(tdiv(mp, 16), 0, 16777215);
                        if (mp < 0) q = 0;
                        r_buf[6] <= q[23:16]; r_buf[7] <= q[15:8]; r_buf[8] <= q[7:0];
                    end
                    4'd3: r_buf[9] <= 8'(clampv(mp, 0, 100));
                    4'd4, 4'd5: begin
                        q = tdiv(mp, 16);
                        r_buf[2 + 4*(r_psel-4)] <= q[31:24];
                        r_buf[3 + 4*(r_psel-4)] <= q[23:16];
                        r_buf[4 + 4*(r_psel-4)] <= q[15:8];
                        r_buf[5 + 4*(r_psel-4)] <= q[7:0];
                    end
                    4'd6, 4'd7: begin
                        q = clampv(tdiv(mp, 16), 0, 65535);
                        r_buf[10 + 2*(r_psel-6)] <= q[15:8];
                        r_buf[11 + 2*(r_psel-6)] <= q[7:0];
                    end
                    4'd8: begin
                        q = mp + 58'sd65536000;
                        q = (q < 0) ? 58'sd0 : clampv(q >>> 16, 0, 65535);
                        r_buf[14] <= q[15:8]; r_buf[15] <= q[7:0];
                    end
                    4'd9: r_buf[16] <= 8'(clampv(mp, 0, 255));
                    4'd10: begin
                        q = clampv(tdiv(mp, 16), -32768, 32767);
                        r_buf[2] <= q[15:8]; r_buf[3] <= q[7:0];
                    end
                    4'd11, 4'd12, 4'd13: begin
                        q = clampv(tdiv(mp, 32), -32768, 32767);
                        r_buf[2 + 2*(r_psel-11)] <= q[15:8];
                        r_buf[3 + 2*(r_psel-11)] <= q[7:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_byte) |-> r_pend)
        else $error("last byte without pending frame");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_tot >= 5'd6))
        else $error("frame too short");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output dropped under stall");
endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRSF telemetry frame scheduler testbench
// Drives store, tick and frame-taken transactions with random gaps, predicts
// every emitted frame byte and checks each output transaction in order.
// Several address and interval settings are applied between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import crsf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    crsf_telemetry_frame_scheduler_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item pending_items[$];
    t_out_item expected_bytes[$];
    logic [7:0] payload[$];
    int fails = 0;
    int cycles = 0;
    bit no_idle = 0;
    logic [31:0] now_cur = 0;

    // Scheduler model
    logic signed [31:0] sensors[NumSensors];
    logic [31:0] last_sent[NumKinds];
    logic [15:0] intervals[NumKinds];
    logic [7:0] dest_addr;
    bit frame_out;

    task automatic report(input string what);
        fails++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic longint sv(input int i);
        return longint'(sensors[i]);
    endfunction

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint pos(input longint x);
        return x < 0 ? 0 : x;
    endfunction

    function automatic logic [7:0] crc8(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int i = 0; i < 8; i++) x = x[7] ? ((x << 1) ^ 8'hD5) : (x << 1);
        return x;
    endfunction

    task automatic push_be(input longint v, input int n);
        for (int i = n - 1; i >= 0; i--) payload.push_back(8'(v >>> (8 * i)));
    endtask

    task automatic encode_kind(input int k);
        longint h, m;
        string nm;
        payload.delete();
        case (k)
            0: begin
                push_be(clamp(pos(sv(0)) * 10 / 65536, 0, 65535), 2);
                push_be(clamp(pos(sv(1)) * 10 / 65536, 0, 65535), 2);
                push_be(clamp(pos(sv(2)) / 65536, 0, 16777215), 3);
                push_be(clamp(sv(3), 0, 100), 1);
            end
            1: begin
                push_be(clamp(sv(4), -180 * 65536, 180 * 65536) * 10000000 / 65536, 4);
                push_be(clamp(sv(5), -180 * 65536, 180 * 65536) * 10000000 / 65536, 4);
                push_be(clamp(pos(sv(6)) * 36 / 65536, 0, 65535), 2);
                h = sv(7) % (360 * 65536);
                if (h < 0) h += 360 * 65536;
                push_be(clamp(h * 100 / 65536, 0, 65535), 2);
                push_be(clamp(pos(sv(8) + 1000 * 65536) / 65536, 0, 65535), 2);
                push_be(clamp(sv(9), 0, 255), 1);
            end
            2: push_be(clamp(sv(10) * 100 / 65536, -32768, 32767), 2);
            3: for (int i = 0; i < 3; i++)
                push_be(clamp(sv(11 + i) * 11438190 / 64'sh1_0000_0000, -32768, 32767), 2);
            default: begin
                m = sv(14);
                case (m)
                    0: nm = "ACRO";
                    1: nm = "ANGLE";
                    2: nm = "HORIZON";
                    3: nm = "GPS";
                    default: nm = "UNKNOWN";
                endcase
                for (int i = 0; i < nm.len(); i++) payload.push_back(nm[i]);
                payload.push_back(8'h00);
            end
        endcase
    endtask

    task automatic predict_frame(input t_in_item it);
        logic [7:0] crc;
        logic [7:0] kind_code[NumKinds];
        kind_code = '{8'h08, 8'h02, 8'h07, 8'h1E, 8'h21};
        if (it.operation == OP_STORE) begin
            if (it.sensor_select < NumSensors) sensors[it.sensor_select] = it.sensor_value;
        end else if (it.operation == OP_TAKEN) begin
            frame_out = 0;
        end else if (it.operation == OP_TICK && !frame_out) begin
            for (int k = 0; k < NumKinds; k++) begin
                if (32'(it.now_ms - last_sent[k]) < {16'h0, intervals[k]}) continue;
                encode_kind(k);
                if (payload.size() + 4 > FrameBufferBytesDef) continue;
                payload.push_front(kind_code[k]);
                crc = '0;
                foreach (payload[i]) crc = crc8(crc, payload[i]);
                payload.push_front(8'(payload.size() + 1));
                payload.push_front(dest_addr);
                payload.push_back(crc);
                foreach (payload[i])
                    expected_bytes.push_back('{payload[i], 3'(k), i == payload.size() - 1});
                last_sent[k] = it.now_ms;
                frame_out = 1;
                break;
            end
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender
    int in_gap = 0;
    always @(posedge i_clk) begin : drive_in
        logic nv;
        if (i_rst_n) begin
            nv = in_valid;
            if (in_valid && !in_stall) begin
                predict_frame(in_data);
                nv = 0;
            end
            if (!nv) begin
                if (in_gap > 0) in_gap--;
                else if (pending_items.size() > 0) begin
                    in_data <= pending_items.pop_front();
                    nv = 1;
                    in_gap = gap_len();
                end
            end
            in_valid <= nv;
        end
    end

    // Receiver
    int stall_left = 0;
    always @(posedge i_clk) begin : watch_out
        t_out_item e;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_bytes.size() == 0) report("unexpected frame byte");
                else begin
                    e = expected_bytes.pop_front();
                    if (out_data.frame_byte !== e.frame_byte)
                        report($sformatf("frame_byte %h, want %h", out_data.frame_byte,
                                         e.frame_byte));
                    if (out_data.frame_kind !== e.frame_kind)
                        report($sformatf("frame_kind %0d, want %0d", out_data.frame_kind,
                                         e.frame_kind));
                    if (out_data.last_byte !== e.last_byte)
                        report($sformatf("last_byte %b, want %b", out_data.last_byte,
                                         e.last_byte));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = gap_len();
                out_stall <= (stall_left > 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL crsf_telemetry_frame_scheduler_core");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [3:0] sel,
                            input logic [31:0] val, input logic [31:0] now);
        pending_items.push_back('{op, sel, val, now});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() > 0 || in_valid || expected_bytes.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_DEST) dest_addr = val[7:0];
        else intervals[idx - REG_BATT_INTV] = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value(input int sel);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom;
        if (sel == 14) return $urandom_range(0, 5);
        if (sel == 3 || sel == 9) return $urandom_range(0, 300) - 20;
        return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endfunction

    task automatic random_run(input int n);
        int r, s;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                s = $urandom_range(0, 14);
                if (s == 13 && $urandom_range(0, 1)) s = 14;
                add_item(OP_STORE, 4'(s), rand_value(s), $urandom);
            end else if (r < 80) begin
                if ($urandom_range(0, 19) == 0) now_cur = $urandom;
                else now_cur += $urandom_range(0, 1200);
                add_item(OP_TICK, 4'($urandom), $urandom, now_cur);
            end else if (r < 96) begin
                add_item(OP_TAKEN, 4'($urandom), $urandom, $urandom);
            end else begin
                add_item(2'd3, 4'($urandom), $urandom, $urandom);
                add_item(OP_STORE, 4'd15, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        foreach (sensors[i]) sensors[i] = '0;
        foreach (last_sent[i]) last_sent[i] = '0;
        intervals = '{16'd1000, 16'd1000, 16'd200, 16'd100, 16'd1000};
        dest_addr = 8'd200;
        frame_out = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every sensor, scheduling and pending rules
        add_item(OP_STORE, 4'd0, 32'h7FFF_FFFF, 0);
        add_item(OP_STORE, 4'd1, 32'h8000_0000, 0);
        add_item(OP_STORE, 4'd2, 32'h7FFF_FFFF, 0);
        add_item(OP_STORE, 4'd3, 32'd150, 0);
        add_item(OP_STORE, 4'd4, 32'h00C8_0000, 0);
        add_item(OP_STORE, 4'd5, 32'h8000_0000, 0);
        add_item(OP_STORE, 4'd6, 32'h7FFF_FFFF, 0);
        add_item(OP_STORE, 4'd7, -32'sh0017_8000, 0);
        add_item(OP_STORE, 4'd8, 32'h8000_0000, 0);
        add_item(OP_STORE, 4'd9, 32'd300, 0);
        add_item(OP_STORE, 4'd10, 32'h7FFF_FFFF, 0);
        add_item(OP_STORE, 4'd11, 32'h8000_0000, 0);
        add_item(OP_STORE, 4'd12, 32'h7FFF_FFFF, 0);
        add_item(OP_STORE, 4'd13, 32'h005A_0000, 0);
        add_item(OP_STORE, 4'd14, 32'd2, 0);
        add_item(OP_TICK, 0, 0, 32'd999);
        add_item(OP_TICK, 0, 0, 32'd1000);
        add_item(OP_TICK, 0, 0, 32'd5000);
        add_item(OP_STORE, 4'd3, -32'sd5, 0);
        add_item(OP_TAKEN, 0, 0, 0);
        add_item(OP_TICK, 0, 0, 32'd1000);
        add_item(OP_TAKEN, 0, 0, 0);
        add_item(OP_TAKEN, 0, 0, 0);
        add_item(2'd3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(OP_STORE, 4'd15, 32'h1234_5678, 0);
        add_item(OP_TICK, 0, 0, 32'hFFFF_FFFF);
        add_item(OP_TAKEN, 0, 0, 0);
        now_cur = 32'hFFFF_FFFF;
        random_run(60);
        wait_idle();

        cfg_write(REG_DEST, 16'd0);
        for (int k = 1; k <= NumKinds; k++) cfg_write(3'(k), 16'd0);
        no_idle = 1;
        random_run(60);
        wait_idle();

        cfg_write(REG_DEST, 16'd255);
        for (int k = 1; k <= NumKinds; k++) cfg_write(3'(k), 16'hFFFF);
        no_idle = 0;
        random_run(60);
        wait_idle();

        cfg_write(REG_DEST, 16'($urandom));
        for (int k = 1; k <= NumKinds; k++) cfg_write(3'(k), 16'($urandom_range(0, 400)));
        random_run(130);
        wait_idle();

        cfg_write(REG_DEST, 16'hFFC8);
        for (int k = 1; k <= NumKinds; k++) cfg_write(3'(k), 16'($urandom_range(0, 1500)));
        random_run(120);
        wait_idle();

        if (fails == 0) $display("PASS crsf_telemetry_frame_scheduler_core");
        else $display("FAIL crsf_telemetry_frame_scheduler_core");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/crsf_pkg.sv
rtl/crsf_mul.sv
rtl/crsf_telemetry_frame_scheduler_core.sv
bench/tb.sv
